// File: sv/crc64bh_pkg.sv
// package: crc-64 polynomial, table type and the byte lookup table
package crc64bh_pkg;

  localparam int unsigned CrcWidth   = 64;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned TableDepth = 1 << ByteWidth;

  // ecma-182 polynomial in reflected bit order
  localparam logic [CrcWidth-1:0] CrcPolyRefl = 64'hC96C_5795_D787_0F42;
  localparam logic [CrcWidth-1:0] CrcInit     = '0;

  typedef logic [CrcWidth-1:0] crc_t;
  typedef crc_t crc_table_t [TableDepth];

  // one table word: eight reflected shift/xor steps
  function automatic crc_t crc_table_word(input logic [ByteWidth-1:0] idx);
    crc_t w;
    w = crc_t'(idx);
    for (int k = 0; k < ByteWidth; k++) begin
      if (w[0]) begin
        w = (w >> 1) ^ CrcPolyRefl;
      end else begin
        w = w >> 1;
      end
    end
    return w;
  endfunction

  function automatic crc_table_t crc_build_table();
    crc_table_t t;
    for (int i = 0; i < TableDepth; i++) begin
      t[i] = crc_table_word(ByteWidth'(i));
    end
    return t;
  endfunction

  // worked out at elaboration, a constant rom
  localparam crc_table_t CrcTable = crc_build_table();

endpackage

// File: sv/crc64_byte_hasher_core.sv
// top level: byte-serial reflected crc-64 hasher with registered input and result
//
// usage
// - input channel (data_valid_i / data_ready_o) carries one word per byte of a
//   message: data_byte_i and last_byte_i; last_byte_i marks the final byte
// - output channel (hash_valid_o / hash_ready_i) carries one word per message:
//   the 64-bit crc (ecma-182, reflected, zero start, no final inversion)
// - every message holds at least one byte; there is no empty message
// - a last byte passes from the input register into the output register once
//   the output register is free or is being emptied; the hash then waits there
//   until the receiver takes it
// - throughput: one byte per cycle unless a last byte waits on a stalled hash;
//   the running crc loops through one table lookup and one 64-bit xor each cycle
// - the input register takes a new word while a finished hash still waits in
//   the output register; only a last byte waits behind a stalled hash
// - reset clears the valid flags and sets the running crc to zero; after each
//   last byte the running crc returns to zero for the next message
// - when the receiver stalls, hash_value_o holds and non-last bytes keep
//   flowing into the running crc
module crc64_byte_hasher_core
  import crc64bh_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 data_valid_i,
  output logic                 data_ready_o,
  input  logic [ByteWidth-1:0] data_byte_i,
  input  logic                 last_byte_i,
  output logic                 hash_valid_o,
  input  logic                 hash_ready_i,
  output logic [CrcWidth-1:0]  hash_value_o
);

  // input register
  logic                 in_valid_q, in_valid_d;
  logic [ByteWidth-1:0] in_byte_q;
  logic                 in_last_q;

  // running crc and result register
  crc_t crc_q, crc_d;
  logic out_valid_q, out_valid_d;
  crc_t hash_q;

  logic                 in_take;
  logic                 step_go;
  logic                 load_hash;
  logic [ByteWidth-1:0] tbl_idx;
  crc_t                 crc_next;

  // the staged byte moves on unless it is a last byte behind a full, stalled result
  assign step_go   = in_valid_q && (!in_last_q || !out_valid_q || hash_ready_i);
  assign load_hash = step_go && in_last_q;

  assign data_ready_o = !in_valid_q || step_go;
  assign in_take      = data_valid_i && data_ready_o;

  // one table step of the reflected crc
  assign tbl_idx  = crc_q[ByteWidth-1:0] ^ in_byte_q;
  assign crc_next = (crc_q >> ByteWidth) ^ CrcTable[tbl_idx];

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (step_go) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    crc_d = crc_q;
    if (step_go) begin
      // message ends: restart from zero
      crc_d = in_last_q ? CrcInit : crc_next;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_hash) begin
      out_valid_d = 1'b1;
    end else if (hash_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      crc_q       <= CrcInit;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      crc_q       <= crc_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
    if (load_hash) begin
      hash_q <= crc_next;
    end
  end

  assign hash_valid_o = out_valid_q;
  assign hash_value_o = hash_q;

endmodule

// File: sv/crc64bh_checker.sv
// checker: port-level assertions for the crc-64 byte hasher, bound to the top level
module crc64bh_checker
  import crc64bh_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 data_valid_i,
  input logic                 data_ready_o,
  input logic [ByteWidth-1:0] data_byte_i,
  input logic                 last_byte_i,
  input logic                 hash_valid_o,
  input logic                 hash_ready_i,
  input logic [CrcWidth-1:0]  hash_value_o
);

  // a hash word waits until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_valid_o && !hash_ready_i |=> hash_valid_o)
    else $error("hash word dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_valid_o && !hash_ready_i |=> $stable(hash_value_o))
    else $error("hash value changed while stalled");

  // with the result register empty, the input side can never be blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hash_valid_o |-> data_ready_o)
    else $error("input blocked with empty result register");

  // a fresh hash needs a last byte that was accepted into the input register before it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(hash_valid_o) |-> $past(data_valid_i && data_ready_o && last_byte_i, 2))
    else $error("hash appeared without a last byte");

  // a waiting input word holds still until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_valid_i && !data_ready_o |=>
      data_valid_i && $stable(data_byte_i) && $stable(last_byte_i))
    else $error("input word changed while waiting");

endmodule

bind crc64_byte_hasher_core crc64bh_checker u_crc64bh_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .data_valid_i (data_valid_i),
  .data_ready_o (data_ready_o),
  .data_byte_i  (data_byte_i),
  .last_byte_i  (last_byte_i),
  .hash_valid_o (hash_valid_o),
  .hash_ready_i (hash_ready_i),
  .hash_value_o (hash_value_o)
);
